### sv/bbtr_pkg.sv
// ----------------------------------------------------------------------------
// bbtr_pkg
// Shared types and constants of the binary block threshold reducer.
// ----------------------------------------------------------------------------
package bbtr_pkg;

  // defaults for the top level parameters
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MAX_BLOCK_DEF = 64;

  // fixed field widths
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned CRD_W     = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned BSZ_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int unsigned QUEUE_DEPTH = 4;

  // reset values of the configuration registers
  localparam logic [DIM_W-1:0] WIDTH_RST     = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST    = DIM_W'(480);
  localparam logic [BSZ_W-1:0] BSIZE_RST     = BSZ_W'(8);
  localparam logic [CNT_W-1:0] THRESHOLD_RST = CNT_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_BLOCK_SIZE     = 2'd2,
    REG_MASS_THRESHOLD = 2'd3
  } cfg_reg_e;

  // segment operation handed from the front to the back, default column width
  typedef struct packed {
    logic [11:0]      col;
    logic [CRD_W-1:0] row;
    logic [CNT_W-1:0] run;
    logic             first;
    logic             bottom;
    logic             last;
  } op_t;

endpackage

### sv/bbtr_if.sv
// ----------------------------------------------------------------------------
// bbtr_if
// Handshake channels of the binary block threshold reducer.
// ----------------------------------------------------------------------------
interface bbtr_pix_if;
  logic valid;
  logic ready;
  logic pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bbtr_red_if;
  logic        valid;
  logic        ready;
  logic        reduced_pixel;
  logic [11:0] reduced_x;
  logic [11:0] reduced_y;
  logic [12:0] block_count;
  logic        last_of_image;

  modport source (output valid, output reduced_pixel, output reduced_x, output reduced_y,
                  output block_count, output last_of_image, input ready);
  modport sink   (input valid, input reduced_pixel, input reduced_x, input reduced_y,
                  input block_count, input last_of_image, output ready);
endinterface

interface bbtr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/bbtr_front.sv
// ----------------------------------------------------------------------------
// bbtr_front
// Raster position tracking and row segment counting; one operation per
// finished block row segment goes to the queue.
// ----------------------------------------------------------------------------
module bbtr_front
  import bbtr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF,
  parameter type         seg_op_t  = op_t,
  localparam int unsigned XW = $clog2(MAX_WIDTH),
  localparam int unsigned BW = $clog2(MAX_BLOCK)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_valid_i,
  input  logic             pix_value_i,
  output logic             pix_ready_o,
  input  logic [XW-1:0]    w_last_i,
  input  logic [CRD_W-1:0] h_last_i,
  input  logic [BW-1:0]    bs_last_i,
  output logic             push_o,
  output seg_op_t          op_o,
  input  logic             full_i
);

  logic [XW-1:0]    px_q, px_d;
  logic [CRD_W-1:0] py_q, py_d;
  logic [BW-1:0]    ox_q, ox_d;
  logic [BW-1:0]    oy_q, oy_d;
  logic [XW-1:0]    bcol_q, bcol_d;
  logic [CRD_W-1:0] brow_q, brow_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] run_next;
  logic             accept;
  logic             row_end, col_end, seg_end, blk_bottom;

  assign pix_ready_o = !full_i;
  assign accept      = pix_valid_i && !full_i;

  assign row_end    = px_q >= w_last_i;
  assign col_end    = py_q >= h_last_i;
  assign seg_end    = row_end || (ox_q >= bs_last_i);
  assign blk_bottom = col_end || (oy_q >= bs_last_i);

  assign run_next = (pix_value_i && run_q != COUNT_MAX) ? run_q + CNT_W'(1) : run_q;

  always_comb begin
    op_o        = '0;
    op_o.col    = bcol_q;
    op_o.row    = brow_q;
    op_o.run    = run_next;
    op_o.first  = (oy_q == '0);
    op_o.bottom = blk_bottom;
    op_o.last   = row_end && col_end;
  end

  assign push_o = accept && seg_end;

  always_comb begin
    px_d   = px_q;
    py_d   = py_q;
    ox_d   = ox_q;
    oy_d   = oy_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    run_d  = run_q;
    if (accept) begin
      run_d = seg_end ? '0 : run_next;
      if (row_end) begin
        px_d   = '0;
        ox_d   = '0;
        bcol_d = '0;
        if (col_end) begin
          py_d   = '0;
          oy_d   = '0;
          brow_d = '0;
        end else begin
          py_d = py_q + CRD_W'(1);
          if (oy_q >= bs_last_i) begin
            oy_d   = '0;
            brow_d = brow_q + CRD_W'(1);
          end else begin
            oy_d = oy_q + BW'(1);
          end
        end
      end else begin
        px_d = px_q + XW'(1);
        if (ox_q >= bs_last_i) begin
          ox_d   = '0;
          bcol_d = bcol_q + XW'(1);
        end else begin
          ox_d = ox_q + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= '0;
      py_q   <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
      bcol_q <= '0;
      brow_q <= '0;
      run_q  <= '0;
    end else begin
      px_q   <= px_d;
      py_q   <= py_d;
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
      run_q  <= run_d;
    end
  end

endmodule

### sv/bbtr_fifo.sv
// ----------------------------------------------------------------------------
// bbtr_fifo
// Short operation queue between the front and the back.
// ----------------------------------------------------------------------------
module bbtr_fifo
  import bbtr_pkg::*;
#(
  parameter int unsigned DEPTH    = QUEUE_DEPTH,
  parameter type         seg_op_t = op_t,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  seg_op_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output seg_op_t data_o
);

  seg_op_t       entry_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

### sv/bbtr_back.sv
// ----------------------------------------------------------------------------
// bbtr_back
// Column count store update and threshold decision, with an output register.
// ----------------------------------------------------------------------------
module bbtr_back
  import bbtr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter type         seg_op_t  = op_t,
  localparam int unsigned XW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] threshold_i,
  input  logic             empty_i,
  input  seg_op_t          head_i,
  output logic             pop_o,
  bbtr_red_if.source       red_o
);

  logic [CNT_W-1:0] cnt_mem [MAX_WIDTH];

  logic             s1_valid_q;
  seg_op_t          s1_op_q;
  logic [CNT_W-1:0] rd_q;
  logic             fwd_valid_q;
  logic [XW-1:0]    fwd_col_q;
  logic [CNT_W-1:0] fwd_val_q;

  logic             out_valid_q;
  logic             out_pix_q;
  logic [CRD_W-1:0] out_x_q, out_y_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_last_q;

  logic             s1_fire, load, wr_en;
  logic [CNT_W-1:0] prior, total;
  logic [CNT_W:0]   sum;

  assign s1_fire = s1_valid_q && (!s1_op_q.bottom || !out_valid_q || red_o.ready);
  assign load    = !empty_i && (!s1_valid_q || s1_fire);
  assign pop_o   = load;
  assign wr_en   = s1_fire && !s1_op_q.bottom;

  // a write at the edge that loaded this op is not yet in rd_q
  always_comb begin
    if (s1_op_q.first) begin
      prior = '0;
    end else if (fwd_valid_q && fwd_col_q == s1_op_q.col) begin
      prior = fwd_val_q;
    end else begin
      prior = rd_q;
    end
  end

  assign sum   = {1'b0, prior} + {1'b0, s1_op_q.run};
  assign total = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (load) begin
      rd_q <= cnt_mem[head_i.col];
    end
    if (wr_en) begin
      cnt_mem[s1_op_q.col] <= total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= wr_en;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_op_q.bottom) begin
        out_valid_q <= 1'b1;
      end else if (red_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_op_q   <= head_i;
      fwd_col_q <= s1_op_q.col;
      fwd_val_q <= total;
    end
    if (s1_fire && s1_op_q.bottom) begin
      out_pix_q  <= (total >= threshold_i);
      out_x_q    <= CRD_W'(s1_op_q.col);
      out_y_q    <= s1_op_q.row;
      out_cnt_q  <= total;
      out_last_q <= s1_op_q.last;
    end
  end

  assign red_o.valid         = out_valid_q;
  assign red_o.reduced_pixel = out_pix_q;
  assign red_o.reduced_x     = out_x_q;
  assign red_o.reduced_y     = out_y_q;
  assign red_o.block_count   = out_cnt_q;
  assign red_o.last_of_image = out_last_q;

endmodule

### sv/binary_block_threshold_reduce.sv
// ----------------------------------------------------------------------------
// binary_block_threshold_reduce
// Reduces a raster binary image to one thresholded pixel per square block.
// ----------------------------------------------------------------------------
// throughput: one pixel, one store read and write a cycle while the queue has room
// a block's last pixel passes the entry queue, store read stage and output register
// a held result stalls the back; input stops only once the four entry queue fills
// reset: registers go to 640x480, block 8, threshold 32, position to zero;
// the column count store is not cleared, each entry is written before it is read
module binary_block_threshold_reduce
  import bbtr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbtr_pix_if.sink   pix_i,
  bbtr_cfg_if.sink   cfg_i,
  bbtr_red_if.source red_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned BW = $clog2(MAX_BLOCK);

  typedef struct packed {
    logic [XW-1:0]    col;
    logic [CRD_W-1:0] row;
    logic [CNT_W-1:0] run;
    logic             first;
    logic             bottom;
    logic             last;
  } col_op_t;

  logic [DIM_W-1:0] width_q, height_q;
  logic [BSZ_W-1:0] bsize_q;
  logic [CNT_W-1:0] thr_q;

  logic [15:0]      w_eff, h_eff;
  logic [8:0]       bs_eff;
  logic [15:0]      w_m1, h_m1;
  logic [8:0]       bs_m1;
  logic [XW-1:0]    w_last;
  logic [CRD_W-1:0] h_last;
  logic [BW-1:0]    bs_last;

  logic    push, full, pop, empty;
  col_op_t op_in, op_head;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      bsize_q  <= BSIZE_RST;
      thr_q    <= THRESHOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:    width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT:   height_q <= cfg_i.data;
        REG_BLOCK_SIZE:     bsize_q  <= cfg_i.data[BSZ_W-1:0];
        REG_MASS_THRESHOLD: thr_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // zero counts as one, oversized values saturate
  always_comb begin
    w_eff = 16'(width_q);
    if (w_eff == '0) begin
      w_eff = 16'd1;
    end else if (w_eff > 16'(MAX_WIDTH)) begin
      w_eff = 16'(MAX_WIDTH);
    end
    h_eff = 16'(height_q);
    if (h_eff == '0) begin
      h_eff = 16'd1;
    end else if (h_eff > 16'(HEIGHT_LIMIT)) begin
      h_eff = 16'(HEIGHT_LIMIT);
    end
    bs_eff = 9'(bsize_q);
    if (bs_eff == '0) begin
      bs_eff = 9'd1;
    end else if (bs_eff > 9'(MAX_BLOCK)) begin
      bs_eff = 9'(MAX_BLOCK);
    end
  end

  assign w_m1    = w_eff - 16'd1;
  assign h_m1    = h_eff - 16'd1;
  assign bs_m1   = bs_eff - 9'd1;
  assign w_last  = w_m1[XW-1:0];
  assign h_last  = h_m1[CRD_W-1:0];
  assign bs_last = bs_m1[BW-1:0];

  bbtr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK),
    .seg_op_t  (col_op_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_value_i (pix_i.pixel_value),
    .pix_ready_o (pix_i.ready),
    .w_last_i    (w_last),
    .h_last_i    (h_last),
    .bs_last_i   (bs_last),
    .push_o      (push),
    .op_o        (op_in),
    .full_i      (full)
  );

  bbtr_fifo #(
    .DEPTH    (QUEUE_DEPTH),
    .seg_op_t (col_op_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (op_head)
  );

  bbtr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .seg_op_t  (col_op_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .empty_i     (empty),
    .head_i      (op_head),
    .pop_o       (pop),
    .red_o       (red_o)
  );

endmodule

### tb/binary_block_threshold_reduce_tb.sv
// ----------------------------------------------------------------------------
// binary_block_threshold_reduce_tb
// Streams whole binary images through the reducer under many register
// settings, tracks block counts alongside the design and checks every reduced
// pixel field by field, with random idling on both sides of the data path.
// ----------------------------------------------------------------------------
module binary_block_threshold_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbtr_pkg::*;

  localparam int unsigned MAX_W          = MAX_WIDTH_DEF;
  localparam int unsigned MAX_B          = MAX_BLOCK_DEF;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic             reduced_pixel;
    logic [CRD_W-1:0] reduced_x;
    logic [CRD_W-1:0] reduced_y;
    logic [CNT_W-1:0] block_count;
    logic             last_of_image;
  } reduced_t;

  logic clk_i;
  logic rst_ni;

  bbtr_pix_if pix ();
  bbtr_cfg_if cfg ();
  bbtr_red_if red ();

  binary_block_threshold_reduce #(
    .MAX_WIDTH(MAX_W),
    .MAX_BLOCK(MAX_B)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .cfg_i (cfg),
    .red_o (red)
  );

  // shadow registers
  logic [DIM_W-1:0] width_reg  = WIDTH_RST;
  logic [DIM_W-1:0] height_reg = HEIGHT_RST;
  logic [BSZ_W-1:0] bsize_reg  = BSIZE_RST;
  logic [CNT_W-1:0] thresh_reg = THRESHOLD_RST;

  // block count tracker
  int unsigned col_partial [MAX_W];
  int unsigned run_sum = 0;
  int unsigned pos_x   = 0;
  int unsigned pos_y   = 0;
  int unsigned off_x   = 0;
  int unsigned off_y   = 0;
  int unsigned blk_col = 0;
  int unsigned blk_row = 0;

  reduced_t    pending_blocks [$];
  int unsigned err_cnt      = 0;
  int unsigned idle_cycles  = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_left    = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void apply_register(cfg_reg_e idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:    width_reg  = data[DIM_W-1:0];
      REG_IMAGE_HEIGHT:   height_reg = data[DIM_W-1:0];
      REG_BLOCK_SIZE:     bsize_reg  = data[BSZ_W-1:0];
      REG_MASS_THRESHOLD: thresh_reg = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void accumulate_pixel(logic value);
    int unsigned w, h, bs, total;
    bit          row_end, col_end, seg_end, bottom;
    reduced_t    r;
    w       = clamp_dim(width_reg, MAX_W);
    h       = clamp_dim(height_reg, HEIGHT_LIMIT);
    bs      = clamp_dim(bsize_reg, MAX_B);
    row_end = pos_x >= w - 1;
    col_end = pos_y >= h - 1;
    seg_end = row_end || off_x >= bs - 1;
    bottom  = col_end || off_y >= bs - 1;
    if (value && run_sum < COUNT_MAX) run_sum++;
    if (seg_end) begin
      total = run_sum;
      // partial count from the rows above in the same block
      if (off_y != 0 && blk_col < MAX_W) total += col_partial[blk_col];
      if (total > COUNT_MAX) total = COUNT_MAX;
      run_sum = 0;
      if (bottom) begin
        r.reduced_pixel = (total >= thresh_reg);
        r.reduced_x     = blk_col[CRD_W-1:0];
        r.reduced_y     = blk_row[CRD_W-1:0];
        r.block_count   = total[CNT_W-1:0];
        r.last_of_image = row_end && col_end;
        pending_blocks.push_back(r);
      end else if (blk_col < MAX_W) begin
        col_partial[blk_col] = total;
      end
    end
    if (row_end) begin
      pos_x   = 0;
      off_x   = 0;
      blk_col = 0;
      if (col_end) begin
        pos_y   = 0;
        off_y   = 0;
        blk_row = 0;
      end else begin
        pos_y++;
        if (off_y >= bs - 1) begin
          off_y = 0;
          blk_row++;
        end else begin
          off_y++;
        end
      end
    end else begin
      pos_x++;
      if (off_x >= bs - 1) begin
        off_x = 0;
        blk_col++;
      end else begin
        off_x++;
      end
    end
  endfunction

  function automatic void check_reduced();
    reduced_t want;
    if (pending_blocks.size() == 0) begin
      $error("reduced pixel for block (%0d,%0d) with nothing expected",
             red.reduced_x, red.reduced_y);
      err_cnt++;
      return;
    end
    want = pending_blocks.pop_front();
    if (red.reduced_pixel !== want.reduced_pixel) begin
      $error("reduced_pixel: expected %0d, got %0d", want.reduced_pixel, red.reduced_pixel);
      err_cnt++;
    end
    if (red.reduced_x !== want.reduced_x) begin
      $error("reduced_x: expected %0d, got %0d", want.reduced_x, red.reduced_x);
      err_cnt++;
    end
    if (red.reduced_y !== want.reduced_y) begin
      $error("reduced_y: expected %0d, got %0d", want.reduced_y, red.reduced_y);
      err_cnt++;
    end
    if (red.block_count !== want.block_count) begin
      $error("block_count: expected %0d, got %0d", want.block_count, red.block_count);
      err_cnt++;
    end
    if (red.last_of_image !== want.last_of_image) begin
      $error("last_of_image: expected %0d, got %0d", want.last_of_image, red.last_of_image);
      err_cnt++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfers are sampled with the values from before the edge
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        apply_register(cfg_reg_e'(cfg.index), cfg.data);
        moved = 1'b1;
      end
      if (pix.valid && pix.ready) begin
        accumulate_pixel(pix.pixel_value);
        moved = 1'b1;
      end
      if (red.valid && red.ready) begin
        check_reduced();
        moved = 1'b1;
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    red.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        red.ready <= 1'b0;
        hold_left--;
      end else begin
        red.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input int unsigned value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value[CFG_DAT_W-1:0];
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input int unsigned w, input int unsigned h,
                             input int unsigned bs, input int unsigned thr);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    cfg_write(REG_BLOCK_SIZE, bs);
    cfg_write(REG_MASS_THRESHOLD, thr);
  endtask

  // density is the chance of a set pixel in percent
  task automatic send_pixels(input int unsigned n, input int unsigned density);
    repeat (n) begin
      while ($urandom_range(99) < src_idle_pct) begin
        pix.valid <= 1'b0;
        @(posedge clk_i);
      end
      pix.valid       <= 1'b1;
      pix.pixel_value <= ($urandom_range(99) < density);
      do @(posedge clk_i); while (!pix.ready);
    end
    pix.valid <= 1'b0;
  endtask

  task automatic run_image(input int unsigned w, input int unsigned h, input int unsigned bs,
                           input int unsigned thr, input int unsigned density);
    load_config(w, h, bs, thr);
    send_pixels(clamp_dim(w, MAX_W) * clamp_dim(h, HEIGHT_LIMIT), density);
  endtask

  // zero size registers act as one, giving a single pixel image
  task automatic test_unit_image();
    run_image(0, 0, 0, 0, 0);
    run_image(1, 1, 1, 1, 100);
    run_image(1, 1, 1, 1, 0);
  endtask

  // clipped edge blocks; upper block size bits are dropped
  task automatic test_clipped_blocks();
    run_image(5, 4, 'h1F83, 3, 50);
    run_image(2, 2, 2, 8191, 100);
  endtask

  // oversized block size saturates; a full block reaches its threshold exactly
  task automatic test_extreme_sizes();
    run_image(70, 1, 127, 32, 50);
    run_image(8, 8, 8, 64, 100);
  endtask

  task automatic test_random_images(input int unsigned item_goal);
    int unsigned sent, w, h, bs, thr, pick, side;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(19);
      w    = (pick == 0) ? 0 : $urandom_range(1, 24);
      h    = (pick == 1) ? 0 : $urandom_range(1, 12);
      bs   = (pick == 2) ? 0 : (pick == 3) ? $urandom_range(65, 127) : $urandom_range(1, 8);
      side = clamp_dim(bs, MAX_B);
      pick = $urandom_range(9);
      thr  = (pick == 0) ? 0 :
             (pick == 1) ? $urandom_range(4097, 8191) : $urandom_range(0, side * side + 1);
      run_image(w, h, bs, thr, $urandom_range(0, 100));
      sent += clamp_dim(w, MAX_W) * clamp_dim(h, HEIGHT_LIMIT);
    end
  endtask

  task automatic test_config_mid_image();
    load_config(12, 9, 3, 4);
    send_pixels(36, 50);
    // narrower image and smaller blocks from the next block row on
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 9);
    cfg_write(REG_BLOCK_SIZE, 2);
    cfg_write(REG_MASS_THRESHOLD, 2);
    send_pixels(9, 50);
    // height cut below the current row, so this row closes the image
    wait_idle();
    cfg_write(REG_IMAGE_HEIGHT, 2);
    send_pixels(9, 50);
  endtask

  // one result per pixel while the receiver holds off, so the input stalls
  task automatic test_input_backpressure();
    load_config(16, 4, 1, 1);
    hold_left = 300;
    send_pixels(64, 50);
  endtask

  initial begin
    rst_ni          = 1'b0;
    pix.valid       = 1'b0;
    pix.pixel_value = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = REG_IMAGE_WIDTH;
    cfg.data        = '0;
    src_idle_pct    = 28;
    snk_idle_pct    = 83;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unit_image();
    test_clipped_blocks();
    test_extreme_sizes();

    src_idle_pct = 83;
    snk_idle_pct = 28;
    test_random_images(150);
    test_config_mid_image();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_images(150);
    test_input_backpressure();

    wait_idle();
    if (err_cnt == 0 && pending_blocks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
